/* sv/pcxe_pkg.sv */
// shared types and constants of the pcx run-length encoder
package pcxe_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 4096;
  localparam int unsigned RESET_WIDTH   = 320;
  localparam int unsigned QUEUE_DEPTH   = 4;

  localparam logic [5:0] RUN_CAP    = 6'd63;
  localparam logic [7:0] COUNT_MARK = 8'hC0;
  localparam logic [7:0] PAD_BYTE   = 8'h00;

  // byte slots of one command, emitted lowest first
  localparam int unsigned SLOT_CNT1 = 0;
  localparam int unsigned SLOT_VAL1 = 1;
  localparam int unsigned SLOT_CNT2 = 2;
  localparam int unsigned SLOT_VAL2 = 3;
  localparam int unsigned SLOT_PAD  = 4;
  localparam int unsigned NUM_SLOTS = 5;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    logic [5:0]           len1;
    logic [7:0]           val1;
    logic [5:0]           len2;
    logic [7:0]           val2;
  } cmd_t;

endpackage

/* sv/pcx_rle_encoder_top.sv */
// top level of the pcx run-length encoder, image body only
// A pixel is taken in any cycle in which the command queue has room, so pixels
// may arrive back to back; the output side delivers one word per cycle while
// the receiver pops, from a single output register. Words per pixel are
// none when it only extends the open run, one for a plain value, two
// for a count word plus value (runs longer than one or values of 0xC0 and up),
// and up to five at a row end (flush of the old run, flush of the new run, pad
// word for odd widths). The sustained rate is therefore set by the output
// register of the back end; the four-entry queue absorbs short bursts.
// Widths of zero count as one, widths above MAX_WIDTH are clamped, and the
// width should only be written while the block is idle.
module pcx_rle_encoder_top #(
  parameter int unsigned MAX_WIDTH = pcxe_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: pixels per row
  input  logic        row_width_we_i,
  input  logic [12:0] row_width_i,
  // pixel input side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  pixel_i,
  // encoded word output side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        last_of_item_o
);
  import pcxe_pkg::*;

  logic accept;
  logic f_push;
  cmd_t f_cmd;
  cmd_t q_cmd;
  logic q_full, q_empty, q_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  // front: run and column tracking, one command per pixel that emits words
  pcxe_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (row_width_we_i),
    .cfg_width_i(row_width_i),
    .accept_i   (accept),
    .pixel_i    (pixel_i),
    .push_o     (f_push),
    .cmd_o      (f_cmd)
  );

  // decoupling queue
  pcxe_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_push),
    .wdata_i(f_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .rdata_o(q_cmd),
    .empty_o(q_empty)
  );

  // back: word sequencer with output register
  pcxe_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (q_cmd),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .out_byte_o(out_byte_o),
    .last_o    (last_of_item_o)
  );

endmodule

/* sv/pcxe_front.sv */
// front end: run tracking, column count and byte command building
module pcxe_front #(
  parameter int unsigned MAX_WIDTH = pcxe_pkg::MAX_WIDTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [12:0]     cfg_width_i,
  input  logic            accept_i,
  input  logic [7:0]      pixel_i,
  output logic            push_o,
  output pcxe_pkg::cmd_t  cmd_o
);
  import pcxe_pkg::*;

  localparam int unsigned CW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW      = CW + 1;
  localparam int unsigned RESET_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

  logic [WW-1:0] width_q, width_d;
  logic [CW-1:0] col_q, col_d;
  logic [5:0]    len_q, len_d;
  logic [7:0]    val_q, val_d;

  logic [31:0]   cfg_w32;
  logic [WW-1:0] col_inc;
  logic          extend, row_end, f1, c1, c2;
  logic [5:0]    nlen;
  logic [7:0]    nval;

  // width is clamped once, at write time
  always_comb begin
    cfg_w32 = {19'd0, cfg_width_i};
    width_d = width_q;
    if (cfg_we_i) begin
      if (cfg_w32 == 32'd0) begin
        width_d = WW'(1);
      end else if (cfg_w32 > 32'(MAX_WIDTH)) begin
        width_d = WW'(MAX_WIDTH);
      end else begin
        width_d = cfg_w32[WW-1:0];
      end
    end
  end

  always_comb begin
    extend  = (len_q != 6'd0) && (pixel_i == val_q) && (len_q < RUN_CAP);
    f1      = !extend && (len_q != 6'd0);
    c1      = (len_q > 6'd1) || (val_q >= COUNT_MARK);
    nlen    = extend ? len_q + 6'd1 : 6'd1;
    nval    = extend ? val_q : pixel_i;
    c2      = (nlen > 6'd1) || (nval >= COUNT_MARK);
    col_inc = {1'b0, col_q} + WW'(1);
    row_end = col_inc >= width_q;

    cmd_o.mask[SLOT_CNT1] = f1 & c1;
    cmd_o.mask[SLOT_VAL1] = f1;
    cmd_o.mask[SLOT_CNT2] = row_end & c2;
    cmd_o.mask[SLOT_VAL2] = row_end;
    cmd_o.mask[SLOT_PAD]  = row_end & width_q[0];
    cmd_o.len1 = len_q;
    cmd_o.val1 = val_q;
    cmd_o.len2 = nlen;
    cmd_o.val2 = nval;

    push_o = accept_i && (cmd_o.mask != '0);

    len_d = len_q;
    val_d = val_q;
    col_d = col_q;
    if (accept_i) begin
      val_d = nval;
      len_d = row_end ? 6'd0 : nlen;
      col_d = row_end ? '0 : col_inc[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WW'(RESET_W);
      col_q   <= '0;
      len_q   <= '0;
      val_q   <= '0;
    end else begin
      width_q <= width_d;
      col_q   <= col_d;
      len_q   <= len_d;
      val_q   <= val_d;
    end
  end

  a_run_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= RUN_CAP)
    else $error("run length above cap");

  a_row_close : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && row_end |=> (len_q == 6'd0) && (col_q == '0))
    else $error("row end left a run or column open");

endmodule

/* sv/pcxe_queue.sv */
// short command queue between front and back end
module pcxe_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pcxe_pkg::cmd_t  wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output pcxe_pkg::cmd_t  rdata_o,
  output logic            empty_o
);
  import pcxe_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  cmd_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = cnt_q == (PW+1)'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (PW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + PW'(1);
      if (do_pop)  rd_q <= rd_q + PW'(1);
      cnt_q <= cnt_d;
    end
  end

  a_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(QUEUE_DEPTH))
    else $error("queue fill count out of range");

endmodule

/* sv/pcxe_back.sv */
// back end: expands commands into one output word per cycle while popped
module pcxe_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pcxe_pkg::cmd_t  cmd_i,
  input  logic            q_empty_i,
  output logic            q_pop_o,
  input  logic            pop_i,
  output logic            empty_o,
  output logic [7:0]      out_byte_o,
  output logic            last_o
);
  import pcxe_pkg::*;

  cmd_t                 cmd_q, cmd_d;
  logic [NUM_SLOTS-1:0] mask_q, mask_d, low;
  logic                 vld_q, vld_d, adv;
  logic [7:0]           byte_q, byte_d, sel;
  logic                 last_q, last_d;

  always_comb begin
    low = mask_q & (~mask_q + NUM_SLOTS'(1));
    unique case (low)
      NUM_SLOTS'(1) << SLOT_CNT1: sel = COUNT_MARK | {2'b00, cmd_q.len1};
      NUM_SLOTS'(1) << SLOT_VAL1: sel = cmd_q.val1;
      NUM_SLOTS'(1) << SLOT_CNT2: sel = COUNT_MARK | {2'b00, cmd_q.len2};
      NUM_SLOTS'(1) << SLOT_VAL2: sel = cmd_q.val2;
      default:                    sel = PAD_BYTE;
    endcase

    adv    = !vld_q || pop_i;
    vld_d  = vld_q;
    byte_d = byte_q;
    last_d = last_q;
    mask_d = mask_q;
    cmd_d  = cmd_q;
    if (adv) begin
      vld_d = mask_q != '0;
      if (mask_q != '0) begin
        byte_d = sel;
        last_d = (mask_q & ~low) == '0;
        mask_d = mask_q & ~low;
      end
    end
    // refill as soon as the current command is used up
    q_pop_o = (mask_d == '0) && !q_empty_i;
    if (q_pop_o) begin
      cmd_d  = cmd_i;
      mask_d = cmd_i.mask;
    end
  end

  assign empty_o    = !vld_q;
  assign out_byte_o = byte_q;
  assign last_o     = last_q;

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    byte_q <= byte_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      mask_q <= '0;
    end else begin
      vld_q  <= vld_d;
      mask_q <= mask_d;
    end
  end

  a_cnt1_pair : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mask_q[SLOT_CNT1] |-> mask_q[SLOT_VAL1])
    else $error("count word without value word, first run");

  a_cnt2_pair : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mask_q[SLOT_CNT2] |-> mask_q[SLOT_VAL2])
    else $error("count word without value word, row-end run");

endmodule

/* bench/tb.sv */
// self-checking bench for pcx_rle_encoder_top: directed rows, random pixel runs, word compare
module tb;

  import pcxe_pkg::*;

  // quiet wait after the last word before a width write, and at the end
  localparam int SETTLE_CYCLES = 16;
  // long receiver hold-off that makes the pixel side back up
  localparam int HOLD_CYCLES   = 80;
  // cycles with no word moving on either side before the run is given up
  localparam int STALL_LIMIT   = 2000;
  // pixels per random segment
  localparam int SEG_PIXELS    = 30;

  // one word the encoder is due to deliver
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } enc_word_t;

  // directed stimulus row: optional width write, then reps copies of one pixel;
  // when fixed is set the words are typed in (first word in the top byte)
  typedef struct packed {
    logic        fixed;
    logic [2:0]  n_words;
    logic        wr;
    logic [12:0] wval;
    logic [7:0]  px;
    logic [6:0]  reps;
    logic [39:0] words;
  } dir_row_t;

  localparam int N_DIR = 21;

  // fixed n  wr  width     pixel  reps  words
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // after reset, width 320: run opens, value below the mark
    '{1, 0, 0, 13'd0,    8'h00, 1,  40'h0},
    '{1, 1, 0, 13'd0,    8'hFF, 1,  {8'h00, 32'h0}},
    '{1, 0, 0, 13'd0,    8'hFF, 1,  40'h0},
    // run of two needs a count word
    '{1, 2, 0, 13'd0,    8'h7F, 1,  {8'hC2, 8'hFF, 24'h0}},
    '{1, 1, 0, 13'd0,    8'hC0, 1,  {8'h7F, 32'h0}},
    // single value at the mark still gets a count word
    '{1, 2, 0, 13'd0,    8'h80, 1,  {8'hC1, 8'hC0, 24'h0}},
    // width cut below the column already reached: row ends at once
    '{1, 2, 1, 13'd4,    8'h80, 1,  {8'hC2, 8'h80, 24'h0}},
    // width zero counts as one, odd so a pad word follows
    '{1, 3, 1, 13'd0,    8'hC5, 1,  {8'hC1, 8'hC5, 8'h00, 16'h0}},
    '{1, 2, 1, 13'd1,    8'h00, 1,  {8'h00, 8'h00, 24'h0}},
    '{1, 3, 0, 13'd0,    8'hFF, 1,  {8'hC1, 8'hFF, 8'h00, 16'h0}},
    // width above the maximum is clamped
    '{0, 0, 1, 13'd8191, 8'h12, 1,  40'h0},
    // mid-row change to an odd width
    '{1, 0, 1, 13'd3,    8'h12, 1,  40'h0},
    '{1, 4, 0, 13'd0,    8'h34, 1,  {8'hC2, 8'h12, 8'h34, 8'h00, 8'h0}},
    // five words from one pixel: old run, new marked run, pad
    '{0, 0, 1, 13'd5,    8'h12, 4,  40'h0},
    '{1, 5, 0, 13'd0,    8'hD0, 1,  {8'hC4, 8'h12, 8'hC1, 8'hD0, 8'h00}},
    // run up to the cap, then an equal pixel starts a fresh run
    '{0, 0, 1, 13'd4096, 8'hAA, 63, 40'h0},
    '{1, 2, 0, 13'd0,    8'hAA, 1,  {8'hFF, 8'hAA, 24'h0}},
    '{0, 0, 0, 13'd0,    8'h00, 1,  40'h0},
    '{0, 0, 1, 13'd2,    8'h01, 1,  40'h0},
    '{0, 0, 0, 13'd0,    8'h55, 6,  40'h0},
    '{0, 0, 1, 13'd320,  8'h3C, 3,  40'h0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        row_width_we_i;
  logic [12:0] row_width_i;
  logic        push;
  logic        full;
  logic [7:0]  pixel_i;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte_o;
  logic        last_of_item_o;

  pcx_rle_encoder_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .row_width_we_i (row_width_we_i),
    .row_width_i    (row_width_i),
    .push           (push),
    .full           (full),
    .pixel_i        (pixel_i),
    .empty          (empty),
    .pop            (pop),
    .out_byte_o     (out_byte_o),
    .last_of_item_o (last_of_item_o)
  );

  // encoder state as the bench sees it
  logic [12:0] mdl_width;
  logic [7:0]  mdl_run_val;
  logic [5:0]  mdl_run_len;
  int unsigned mdl_col;

  logic [7:0]  enc_bytes [$];   // words caused by the pixel just taken
  enc_word_t   words_due [$];   // words still owed by the encoder, oldest first
  enc_word_t   head_word;

  int mismatches = 0;
  int quiet_cycles = 0;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_pending;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // close the open run: count word when longer than one or marked value
  task automatic flush_open_run();
    if (mdl_run_len != 0) begin
      if (mdl_run_len > 1 || mdl_run_val >= COUNT_MARK)
        enc_bytes.push_back(COUNT_MARK | {2'b00, mdl_run_len});
      enc_bytes.push_back(mdl_run_val);
      mdl_run_len = '0;
    end
  endtask

  // words one pixel causes, and the state after it
  task automatic encode_pixel(input logic [7:0] px);
    int unsigned w;
    w = mdl_width;
    if (w == 0)
      w = 1;
    if (w > MAX_WIDTH_DEF)
      w = MAX_WIDTH_DEF;
    enc_bytes.delete();
    if (mdl_run_len != 0 && px == mdl_run_val && mdl_run_len < RUN_CAP) begin
      mdl_run_len++;
    end else begin
      flush_open_run();
      mdl_run_val = px;
      mdl_run_len = 6'd1;
    end
    mdl_col++;
    // row end: runs never cross it, odd widths add a pad word
    if (mdl_col >= w) begin
      flush_open_run();
      if (w[0])
        enc_bytes.push_back(PAD_BYTE);
      mdl_col = 0;
    end
  endtask

  // offer one pixel until taken, then queue the words it owes;
  // push is left high so a following pixel goes out back to back
  task automatic send_pixel(input logic [7:0] px, input logic fixed,
                            input logic [2:0] n_words, input logic [39:0] words);
    int k;
    enc_word_t w;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    pixel_i <= px;
    @(posedge clk_i);
    while (full)
      @(posedge clk_i);
    encode_pixel(px);
    if (fixed) begin
      enc_bytes.delete();
      for (k = 0; k < n_words; k++)
        enc_bytes.push_back(words[39 - 8 * k -: 8]);
    end
    for (k = 0; k < enc_bytes.size(); k++) begin
      w.data = enc_bytes[k];
      w.last = (k == enc_bytes.size() - 1);
      words_due.push_back(w);
    end
  endtask

  // width writes only once the encoder has gone quiet
  task automatic set_width(input logic [12:0] w);
    push <= 1'b0;
    while (words_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    row_width_we_i <= 1'b1;
    row_width_i    <= w;
    @(posedge clk_i);
    row_width_we_i <= 1'b0;
    mdl_width = w;
  endtask

  // mostly runs of random length and value, high values often, now and then
  // a long run around the cap; the rest single noise pixels
  task automatic send_run_segment(input int count);
    int sent;
    int len;
    int i;
    logic [7:0] val;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 70) begin
        if ($urandom_range(0, 1) == 1)
          val = 8'($urandom_range(192, 255));
        else
          val = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0)
          len = $urandom_range(60, 70);
        else
          len = $urandom_range(1, 6);
      end else begin
        val = 8'($urandom);
        len = 1;
      end
      for (i = 0; i < len; i++)
        send_pixel(val, 1'b0, 3'd0, 40'd0);
      sent += len;
    end
  endtask

  // receiver: random pop, or one long hold when asked
  initial begin
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_pending = 1'b0;
      end
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // word compare against the oldest word owed
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (words_due.size() == 0) begin
        $error("unexpected word: out_byte %02h last_of_item %0b", out_byte_o, last_of_item_o);
        mismatches++;
      end else begin
        head_word = words_due.pop_front();
        if (out_byte_o !== head_word.data) begin
          $error("out_byte: expected %02h, got %02h", head_word.data, out_byte_o);
          mismatches++;
        end
        if (last_of_item_o !== head_word.last) begin
          $error("last_of_item: expected %0b, got %0b", head_word.last, last_of_item_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog: gives up when no word moves on either side for too long
  always @(posedge clk_i) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int i;
    int seg;
    logic [12:0] w;

    rst_ni         <= 1'b0;
    push           <= 1'b0;
    pixel_i        <= '0;
    row_width_we_i <= 1'b0;
    row_width_i    <= '0;
    hold_pending   = 1'b0;
    send_idle_pct  = 26;
    recv_idle_pct  = 85;
    mdl_width      = 13'(RESET_WIDTH);
    mdl_run_val    = '0;
    mdl_run_len    = '0;
    mdl_col        = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    for (i = 0; i < N_DIR; i++) begin
      if (DIR_ROWS[i].wr)
        set_width(DIR_ROWS[i].wval);
      repeat (DIR_ROWS[i].reps)
        send_pixel(DIR_ROWS[i].px, DIR_ROWS[i].fixed, DIR_ROWS[i].n_words,
                   DIR_ROWS[i].words);
    end

    // random segments: two per idling mode, a fresh width for each
    for (seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 85;
        end
        1: begin
          send_idle_pct = 85;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (seg)
        0: w = 13'($urandom_range(1, 12));
        1: w = 13'd1;
        2: w = 13'd4096;
        3: w = 13'($urandom_range(2, 40));
        4: w = 13'd2;
        default: w = 13'($urandom_range(0, 8191));
      endcase
      set_width(w);
      // back up the pixel side once while the receiver sits still
      if (seg == 0)
        hold_pending = 1'b1;
      send_run_segment(SEG_PIXELS);
    end

    push <= 1'b0;
    while (words_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
